### hw/rtl/ltbe_pkg.sv
package ltbe_pkg;

    // Geometry and configuration
    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int FRAME_WIDTH_W     = 11;
    localparam int FRAME_HEIGHT_W    = 12;
    localparam int THRESHOLD_W       = 8;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 12;
    localparam int ROW_W             = 13;   // rows 0 .. height+1

    localparam logic [FRAME_WIDTH_W-1:0]  RESET_FRAME_WIDTH    = 11'd780;
    localparam logic [FRAME_HEIGHT_W-1:0] RESET_FRAME_HEIGHT   = 12'd1052;
    localparam logic [THRESHOLD_W-1:0]    RESET_LUMA_THRESHOLD = 8'd60;

    // Luminance weights over 65536
    localparam int WEIGHT_RED   = 13933;
    localparam int WEIGHT_GREEN = 46871;
    localparam int WEIGHT_BLUE  = 4732;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_LUMA_THRESHOLD = 2'd2
    } reg_index_t;

    // What an accepted transaction does once it reaches the window
    typedef enum logic [1:0] {
        OP_NONE,    // ignored transaction, no result
        OP_PIXEL,   // pixel inside the frame
        OP_DRAIN,   // flush tick over the replicated bottom row
        OP_LAST     // flush tick giving the final result of the frame
    } op_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic edge_pixel;
        logic end_of_frame;
    } result_t;

    // Position information carried with a transaction
    typedef struct packed {
        op_t  op;
        logic col_zero;
        logic col_one;
        logic row_one;
        logic row_ge1;
        logic row_ge2;
    } stage_flags_t;

endpackage

### hw/rtl/ltbe_line_store.sv
module ltbe_line_store #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data
);

    // bit 1: upper row, bit 0: middle row
    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/ltbe_luma.sv
module ltbe_luma (
    input  logic       clk,
    input  logic       load,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] threshold,
    output logic       white
);

    import ltbe_pkg::*;

    logic [21:0] red_prod_reg;
    logic [23:0] green_prod_reg;
    logic [20:0] blue_prod_reg;
    logic [21:0] red_prod_next;
    logic [23:0] green_prod_next;
    logic [20:0] blue_prod_next;
    logic [23:0] luma_sum;

    // Weighted components, registered with the transaction
    always_comb
    begin
        red_prod_next   = 22'(red)   * 22'(WEIGHT_RED);
        green_prod_next = 24'(green) * 24'(WEIGHT_GREEN);
        blue_prod_next  = 21'(blue)  * 21'(WEIGHT_BLUE);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_prod_reg   <= red_prod_next;
            green_prod_reg <= green_prod_next;
            blue_prod_reg  <= blue_prod_next;
        end
    end

    // Sum never exceeds 255 * 65536, so 24 bits hold it
    always_comb
    begin
        luma_sum = 24'(red_prod_reg) + green_prod_reg + 24'(blue_prod_reg);
        white    = (luma_sum > {threshold, 16'h0000});
    end

endmodule

### hw/rtl/ltbe_window.sv
module ltbe_window (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  ltbe_pkg::stage_flags_t flags,
    input  logic                   upper,
    input  logic                   middle,
    input  logic                   white,
    output logic                   has_result,
    output logic                   edge_pixel,
    output logic                   store_wr_en,
    output logic [1:0]             store_wr_data
);

    import ltbe_pkg::*;

    // Two newest columns: [2:0] newest, [5:3] previous; bit 0 top, bit 2 bottom
    logic [5:0] window_reg;
    logic [5:0] window_next;
    logic [2:0] column;
    logic [2:0] left;
    logic       border_edge;
    logic       inner_edge;

    function automatic logic judge(input logic [2:0] l, input logic [2:0] c,
                                   input logic [2:0] r);
        logic all_white;
        all_white = (&l) & (&c) & (&r);
        return all_white ? 1'b0 : c[1];
    endfunction

    // Column entering the window
    always_comb
    begin
        if (flags.op == OP_PIXEL)
        begin
            column = {white, middle, (flags.row_one ? middle : upper)};
        end
        else
        begin
            column = {middle, middle, upper};
        end
    end

    // Right border uses the window before the push, inner pixels after it
    always_comb
    begin
        left        = flags.col_one ? window_reg[2:0] : window_reg[5:3];
        border_edge = judge(window_reg[5:3], window_reg[2:0], window_reg[2:0]);
        inner_edge  = judge(left, window_reg[2:0], column);
    end

    always_comb
    begin
        has_result  = 1'b0;
        window_next = window_reg;
        unique case (flags.op)
            OP_NONE:
            begin
                has_result = 1'b0;
            end
            OP_PIXEL:
            begin
                has_result  = flags.col_zero ? flags.row_ge2 : flags.row_ge1;
                window_next = {window_reg[2:0], column};
            end
            OP_DRAIN:
            begin
                has_result  = 1'b1;
                window_next = {window_reg[2:0], column};
            end
            OP_LAST:
            begin
                has_result  = 1'b1;
                window_next = '0;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
        edge_pixel = (flags.col_zero || flags.op == OP_LAST) ? border_edge : inner_edge;
    end

    // Line store update: middle row moves up, new bit becomes middle
    assign store_wr_en   = advance && (flags.op == OP_PIXEL);
    assign store_wr_data = {middle, white};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (advance)
        begin
            window_reg <= window_next;
        end
    end

endmodule

### hw/rtl/luma_threshold_boundary_extract_unit.sv
// Stage A holds a transaction, its result is registered as it leaves; in stream terms
// the result for a pixel comes with the transaction frame_width+1 later.
// Throughput: one transaction per cycle while the output accepts, set by the line store
// with separate read and write ports, read at acceptance, written as stage A moves on.
// Reset: configuration returns to its defaults, counters and window clear; the line
// store is not cleared, the first row of a frame writes it and what it reads never
// reaches a result.
module luma_threshold_boundary_extract_unit #(
    parameter int MAX_WIDTH = ltbe_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [ltbe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ltbe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ltbe_pkg::pixel_in_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ltbe_pkg::result_t                   out_data
);

    import ltbe_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (CW > FRAME_WIDTH_W) ? CW : FRAME_WIDTH_W;

    // Configuration registers
    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [THRESHOLD_W-1:0]    luma_threshold_reg;

    // Frame position of the next transaction
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    // Stage holding the transaction while the line store read completes
    logic         valid_a_reg;
    logic         valid_a_next;
    stage_flags_t flags_a_reg;
    stage_flags_t flags_next;
    logic [AW-1:0] addr_a_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    result_t       out_data_reg;

    logic [XW-1:0]    width_x;
    logic [CW-1:0]    eff_width;
    logic [ROW_W-1:0] eff_height;
    logic [CW-1:0]    col_inc;
    logic             in_accept;
    logic             a_move;
    logic             out_slot_free;
    logic             has_result;
    logic             edge_pixel;
    logic             white;
    logic [1:0]       store_rd_data;
    logic             store_wr_en;
    logic [1:0]       store_wr_data;

    // Clamped frame sizes
    always_comb
    begin
        width_x = XW'(frame_width_reg);
        priority if (width_x < XW'(3))
        begin
            width_x = XW'(3);
        end
        else if (width_x > XW'(MAX_WIDTH))
        begin
            width_x = XW'(MAX_WIDTH);
        end
        eff_width  = CW'(width_x);
        eff_height = (frame_height_reg < FRAME_HEIGHT_W'(3)) ? ROW_W'(3)
                                                            : ROW_W'(frame_height_reg);
    end

    // Handshake: the stage moves on when it has no result or the output slot frees
    assign out_slot_free = !out_valid_reg || out_ready;
    assign a_move        = valid_a_reg && (!has_result || out_slot_free);
    assign in_ready      = !valid_a_reg || a_move;
    assign in_accept     = in_valid && in_ready;

    // Classify the incoming transaction against the frame position
    always_comb
    begin
        flags_next.col_zero = (col_reg == '0);
        flags_next.col_one  = (col_reg == CW'(1));
        flags_next.row_one  = (row_reg == ROW_W'(1));
        flags_next.row_ge1  = (row_reg >= ROW_W'(1));
        flags_next.row_ge2  = (row_reg >= ROW_W'(2));
        priority if (!in_data.req_type && (row_reg < eff_height))
        begin
            flags_next.op = OP_PIXEL;
        end
        else if (in_data.req_type && (row_reg == eff_height))
        begin
            flags_next.op = OP_DRAIN;
        end
        else if (in_data.req_type && (row_reg > eff_height))
        begin
            flags_next.op = OP_LAST;
        end
        else
        begin
            flags_next.op = OP_NONE;
        end
    end

    // Position update at acceptance
    always_comb
    begin
        col_inc  = col_reg + CW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            unique case (flags_next.op)
                OP_NONE:
                begin
                    col_next = col_reg;
                end
                OP_LAST:
                begin
                    col_next = '0;
                    row_next = '0;
                end
                OP_PIXEL, OP_DRAIN:
                begin
                    if (col_inc >= eff_width)
                    begin
                        col_next = '0;
                        row_next = row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        valid_a_next = valid_a_reg;
        if (in_accept)
        begin
            valid_a_next = 1'b1;
        end
        else if (a_move)
        begin
            valid_a_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (a_move && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= RESET_FRAME_WIDTH;
            frame_height_reg   <= RESET_FRAME_HEIGHT;
            luma_threshold_reg <= RESET_LUMA_THRESHOLD;
            col_reg            <= '0;
            row_reg            <= '0;
            valid_a_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        frame_width_reg <= cfg_data[FRAME_WIDTH_W-1:0];
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        frame_height_reg <= cfg_data[FRAME_HEIGHT_W-1:0];
                    end
                    REG_LUMA_THRESHOLD:
                    begin
                        luma_threshold_reg <= cfg_data[THRESHOLD_W-1:0];
                    end
                    default:
                    begin
                        frame_width_reg <= frame_width_reg;
                    end
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            valid_a_reg   <= valid_a_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            flags_a_reg <= flags_next;
            addr_a_reg  <= col_reg[AW-1:0];
        end
        if (a_move && has_result)
        begin
            out_data_reg.edge_pixel   <= edge_pixel;
            out_data_reg.end_of_frame <= (flags_a_reg.op == OP_LAST);
        end
    end

    ltbe_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (col_reg[AW-1:0]),
        .rd_data (store_rd_data),
        .wr_en   (store_wr_en),
        .wr_addr (addr_a_reg),
        .wr_data (store_wr_data)
    );

    ltbe_luma u_luma (
        .clk       (clk),
        .load      (in_accept),
        .red       (in_data.red),
        .green     (in_data.green),
        .blue      (in_data.blue),
        .threshold (luma_threshold_reg),
        .white     (white)
    );

    ltbe_window u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (a_move),
        .flags         (flags_a_reg),
        .upper         (store_rd_data[1]),
        .middle        (store_rd_data[0]),
        .white         (white),
        .has_result    (has_result),
        .edge_pixel    (edge_pixel),
        .store_wr_en   (store_wr_en),
        .store_wr_data (store_wr_data)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### sim/boundary_checker.sv
// Watches the configuration port and both streaming channels, predicts the
// boundary map of every accepted transaction and compares it with what leaves.
module boundary_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [ltbe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ltbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  ltbe_pkg::pixel_in_t              in_data,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  ltbe_pkg::result_t                out_data,
    output int                               pending_results,
    output int                               mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ltbe_pkg::*;

    localparam int  LINE_DEPTH = DEFAULT_MAX_WIDTH;
    localparam logic REQ_PIXEL = 1'b0;

    // Own copy of the configuration
    logic [FRAME_WIDTH_W-1:0]  width_reg;
    logic [FRAME_HEIGHT_W-1:0] height_reg;
    logic [THRESHOLD_W-1:0]    threshold_reg;

    // Own copy of the window state
    logic        line_upper  [0:LINE_DEPTH-1];
    logic        line_middle [0:LINE_DEPTH-1];
    logic [8:0]  window;
    int unsigned col_pos;
    int unsigned row_pos;

    result_t     expected_edges[$];
    result_t     want;
    int unsigned result_index;

    task automatic report_mismatch(input string what);
        // keep the log short if the block is badly broken
        if (mismatch_count < 100)
            $display("%0t ns: result %0d mismatch: %s", $time, result_index, what);
        mismatch_count++;
    endtask

    // Centre pixel survives unless the whole 3x3 neighbourhood is white
    function automatic logic boundary_of(input logic [2:0] left, input logic [2:0] centre,
                                         input logic [2:0] right);
        if (left == 3'b111 && centre == 3'b111 && right == 3'b111)
            return 1'b0;
        return centre[1];
    endfunction

    task automatic predict_edges(input pixel_in_t px);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        int unsigned luma;
        logic        white;
        logic        top_bit;
        logic        boundary;
        logic        produce;
        logic        frame_end;

        w = (width_reg < 3) ? 3 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
        h = (height_reg < 3) ? 3 : height_reg;
        idx = (col_pos < LINE_DEPTH) ? col_pos : 0;
        boundary = 1'b0;
        produce = 1'b0;
        frame_end = 1'b0;

        if (px.req_type == REQ_PIXEL) begin
            // pixel arriving while the frame drains is dropped
            if (row_pos >= h)
                return;
            luma = WEIGHT_RED * px.red + WEIGHT_GREEN * px.green + WEIGHT_BLUE * px.blue;
            white = (luma > {threshold_reg, 16'h0000});
            // first pixel of a row closes the right border of the row above
            if (col_pos == 0 && row_pos >= 2) begin
                boundary = boundary_of(window[5:3], window[2:0], window[2:0]);
                produce = 1'b1;
            end
            top_bit = (row_pos == 1) ? line_middle[idx] : line_upper[idx];
            window = {window[5:0], white, line_middle[idx], top_bit};
            if (col_pos >= 1 && row_pos >= 1) begin
                boundary = boundary_of((col_pos >= 2) ? window[8:6] : window[5:3],
                                       window[5:3], window[2:0]);
                produce = 1'b1;
            end
            line_upper[idx] = line_middle[idx];
            line_middle[idx] = white;
        end else begin
            // flush before the frame is complete is dropped
            if (row_pos < h)
                return;
            if (row_pos > h) begin
                boundary = boundary_of(window[5:3], window[2:0], window[2:0]);
                frame_end = 1'b1;
                produce = 1'b1;
            end else begin
                if (col_pos == 0) begin
                    boundary = boundary_of(window[5:3], window[2:0], window[2:0]);
                    produce = 1'b1;
                end
                // bottom row replicated below the frame
                window = {window[5:0], line_middle[idx], line_middle[idx], line_upper[idx]};
                if (col_pos >= 1) begin
                    boundary = boundary_of((col_pos >= 2) ? window[8:6] : window[5:3],
                                           window[5:3], window[2:0]);
                    produce = 1'b1;
                end
            end
        end

        if (frame_end) begin
            col_pos = 0;
            row_pos = 0;
            window = '0;
        end else begin
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
        end

        if (produce)
            expected_edges.push_back('{edge_pixel: boundary, end_of_frame: frame_end});
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg = RESET_FRAME_WIDTH;
            height_reg = RESET_FRAME_HEIGHT;
            threshold_reg = RESET_LUMA_THRESHOLD;
            for (int i = 0; i < LINE_DEPTH; i++) begin
                line_upper[i] = 1'b0;
                line_middle[i] = 1'b0;
            end
            window = '0;
            col_pos = 0;
            row_pos = 0;
            result_index = 0;
            expected_edges.delete();
            mismatch_count = 0;
            pending_results <= 0;
        end else begin
            // register writes
            if (cfg_write_en) begin
                case (reg_index_t'(cfg_index))
                    REG_FRAME_WIDTH:    width_reg = cfg_data[FRAME_WIDTH_W-1:0];
                    REG_FRAME_HEIGHT:   height_reg = cfg_data[FRAME_HEIGHT_W-1:0];
                    REG_LUMA_THRESHOLD: threshold_reg = cfg_data[THRESHOLD_W-1:0];
                    default: ;
                endcase
            end

            // input transaction
            if (in_valid && in_ready)
                predict_edges(in_data);

            // output transaction
            if (out_valid && out_ready) begin
                if (expected_edges.size() == 0) begin
                    report_mismatch($sformatf("unexpected result edge_pixel=%0b end_of_frame=%0b",
                                              out_data.edge_pixel, out_data.end_of_frame));
                end else begin
                    want = expected_edges.pop_front();
                    if (out_data.edge_pixel !== want.edge_pixel)
                        report_mismatch($sformatf("edge_pixel got %0b want %0b",
                                                  out_data.edge_pixel, want.edge_pixel));
                    if (out_data.end_of_frame !== want.end_of_frame)
                        report_mismatch($sformatf("end_of_frame got %0b want %0b",
                                                  out_data.end_of_frame, want.end_of_frame));
                end
                result_index++;
            end

            pending_results <= expected_edges.size();
        end
    end

endmodule

### sim/luma_threshold_boundary_extract_unit_test.sv
module luma_threshold_boundary_extract_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ltbe_pkg::*;

    localparam int   RANDOM_ITEMS = 1500;
    localparam int   QUIET_LIMIT  = 20000;
    localparam int   HOLD_CYCLES  = 400;
    localparam logic REQ_PIXEL    = 1'b0;
    localparam logic REQ_FLUSH    = 1'b1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    pixel_in_t              in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    result_t                out_data;

    int                     pending_results;
    int                     mismatch_count;

    // stimulus bookkeeping
    int unsigned            frame_w;
    int unsigned            frame_h;
    logic [7:0]             luma_level;
    int unsigned            counted_items = 0;
    int unsigned            idle_phase = 0;
    bit                     stall_receiver = 1'b0;
    bit                     stall_served = 1'b0;
    int unsigned            quiet_cycles = 0;

    always #2 clk = ~clk;

    luma_threshold_boundary_extract_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    boundary_checker boundary_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    function automatic pixel_in_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        return '{req_type: REQ_PIXEL, red: r, green: g, blue: b};
    endfunction

    // colour payload of a flush is random, the block must ignore it
    function automatic pixel_in_t make_flush();
        return '{req_type: REQ_FLUSH, red: 8'($urandom), green: 8'($urandom),
                 blue: 8'($urandom)};
    endfunction

    // Mostly bright or dark against the current threshold, some fully random
    function automatic pixel_in_t random_pixel(input int unsigned bright_pct);
        if ($urandom_range(99) < 10)
            return make_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(99) < bright_pct)
            return make_pixel(8'($urandom_range(255, luma_level)),
                              8'($urandom_range(255, luma_level)),
                              8'($urandom_range(255, luma_level)));
        return make_pixel(8'($urandom_range(luma_level, 0)),
                          8'($urandom_range(luma_level, 0)),
                          8'($urandom_range(luma_level, 0)));
    endfunction

    // Offer one transaction, with a random gap in front of it
    task automatic offer(input pixel_in_t px);
        int unsigned idle_pct;
        idle_phase = (counted_items * 3 / RANDOM_ITEMS > 2) ? 2 : counted_items * 3 / RANDOM_ITEMS;
        idle_pct = (idle_phase == 0) ? 37 : (idle_phase == 1) ? 71 : 0;
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drain everything, let the pipeline settle, then write all three registers
    task automatic settle_and_configure(input logic [11:0] width_val,
                                        input logic [11:0] height_val,
                                        input logic [11:0] threshold_val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= width_val;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data <= height_val;
        @(posedge clk);
        cfg_index <= REG_LUMA_THRESHOLD;
        cfg_data <= threshold_val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        frame_w = 32'(width_val[10:0]);
        if (frame_w < 3)
            frame_w = 3;
        else if (frame_w > DEFAULT_MAX_WIDTH)
            frame_w = DEFAULT_MAX_WIDTH;
        frame_h = (height_val < 3) ? 3 : height_val;
        luma_level = threshold_val[7:0];
    endtask

    // One whole frame plus its drain; optional stray transactions that must be ignored
    task automatic send_frame(input int unsigned bright_pct, input bit noisy);
        for (int unsigned r = 0; r < frame_h; r++) begin
            for (int unsigned c = 0; c < frame_w; c++) begin
                if (noisy && $urandom_range(99) < 3)
                    offer(make_flush());
                offer(random_pixel(bright_pct));
                counted_items++;
            end
        end
        for (int unsigned i = 0; i <= frame_w; i++) begin
            if (noisy && $urandom_range(99) < 3)
                offer(random_pixel(50));
            offer(make_flush());
            counted_items++;
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge clk);
            if (stall_receiver && !stall_served) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_served = 1'b1;
            end
            out_ready <= ($urandom_range(99) >=
                          ((idle_phase == 0) ? 71 : (idle_phase == 1) ? 37 : 0));
        end
    end

    // Watchdog on cycles with no transaction of any kind
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("luma_threshold_boundary_extract_unit test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned roll;
        logic [11:0] width_val;
        logic [11:0] height_val;
        logic [11:0] threshold_val;
        int unsigned bright_pct;
        bit          first_random;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: 3x3 frame; width has its top bit set and clamps, height clamps
        settle_and_configure(12'h802, 12'd1, {4'hA, 8'd60});
        offer(make_flush());                    // flush mid-frame, ignored
        offer(make_pixel(8'd255, 8'd255, 8'd255));
        offer(make_pixel(8'd255, 8'd255, 8'd255));
        offer(make_pixel(8'd0, 8'd0, 8'd255));  // blue only, dark
        offer(make_pixel(8'd255, 8'd255, 8'd255));
        offer(make_pixel(8'd255, 8'd255, 8'd255));
        offer(make_pixel(8'd255, 8'd0, 8'd0));  // red only, dark
        offer(make_pixel(8'd0, 8'd255, 8'd0));  // green only, bright
        offer(make_pixel(8'd61, 8'd61, 8'd61)); // just above threshold
        offer(make_pixel(8'd60, 8'd60, 8'd60)); // equal to threshold, stays black
        offer(make_flush());
        offer(make_flush());
        offer(make_flush());
        offer(make_pixel(8'd255, 8'd255, 8'd255)); // pixel while draining, ignored
        offer(make_flush());

        // Threshold extremes, a clamped height and a tall narrow frame
        settle_and_configure(12'd40, 12'd0, {4'h5, 8'd0});
        send_frame(50, 1'b0);
        settle_and_configure(12'd3, 12'd100, {4'h0, 8'd255});
        send_frame(50, 1'b0);

        // Random frames over the three idling phases
        counted_items = 0;
        first_random = 1'b1;
        while (counted_items < RANDOM_ITEMS || !stall_receiver) begin
            if (idle_phase == 2 && !stall_receiver) begin
                // long enough frame for the block to fill during the hold-off
                settle_and_configure(12'd24, 12'd6, 12'($urandom_range(40, 200)));
                stall_receiver = 1'b1;
            end else if (first_random || $urandom_range(99) < 40) begin
                roll = $urandom_range(99);
                if (roll < 4)
                    width_val = 12'($urandom_range(0, 2));
                else if (roll < 6)
                    // bit above the width field is dropped
                    width_val = 12'h800 | 12'($urandom_range(3, 16));
                else if (roll < 16)
                    width_val = 12'($urandom_range(17, 128));
                else
                    width_val = 12'($urandom_range(3, 16));
                if (roll >= 4 && roll < 16)
                    height_val = 12'($urandom_range(0, 4));
                else if ($urandom_range(99) < 5)
                    height_val = 12'($urandom_range(0, 2));
                else
                    height_val = 12'($urandom_range(3, 10));
                roll = $urandom_range(99);
                threshold_val[11:8] = 4'($urandom_range(0, 15));
                threshold_val[7:0] = (roll < 10) ? 8'd0 : (roll < 20) ? 8'd255 : 8'($urandom);
                settle_and_configure(width_val, height_val, threshold_val);
                first_random = 1'b0;
            end
            case ($urandom_range(2))
                0:       bright_pct = 10;
                1:       bright_pct = 50;
                default: bright_pct = 90;
            endcase
            send_frame(bright_pct, $urandom_range(99) < 50);
        end

        // Wind down and give the verdict
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("luma_threshold_boundary_extract_unit test passed");
        else
            $display("luma_threshold_boundary_extract_unit test failed");
        $finish;
    end

endmodule
